### rtl/eth5t_pkg.sv
// Shared types and constants of the Ethernet IPv4 five-tuple parser.
package eth5t_pkg;

    // Default width of the frame byte counter
    localparam int LENGTH_WIDTH_DEF = 16;

    // Byte positions within the frame, counted from the first destination MAC byte
    localparam int POS_ETYPE_HI  = 12;
    localparam int POS_ETYPE_LO  = 13;
    localparam int POS_IHL       = 14;
    localparam int POS_FRAG_HI   = 20;
    localparam int POS_FRAG_LO   = 21;
    localparam int POS_PROTO     = 23;
    localparam int POS_SRC_FIRST = 26;
    localparam int POS_SRC_LAST  = 29;
    localparam int POS_DST_FIRST = 30;
    localparam int POS_DST_LAST  = 33;

    // Header sizes in bytes
    localparam int ETH_HDR_LEN  = 14;
    localparam int IPV4_MIN_LEN = 20;
    localparam int TCP_HDR_LEN  = 20;
    localparam int UDP_HDR_LEN  = 8;

    // Smallest legal IPv4 header length in 32-bit words
    localparam logic [3:0] MIN_IHL = 4'd5;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // One result item
    typedef struct packed {
        logic        accepted;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol_number;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
        logic [15:0] frame_length;
    } t_result;

endpackage

### rtl/eth5t_if.sv
// Valid/ready channel interfaces for frame bytes and for result items.
interface eth5t_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eth5t_result_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol_number;
    logic [15:0] src_l4_port;
    logic [15:0] dst_l4_port;
    logic [15:0] frame_length;

    modport source (output valid, output accepted, output src_addr, output dst_addr,
                    output protocol_number, output src_l4_port, output dst_l4_port,
                    output frame_length, input ready);
    modport sink   (input valid, input accepted, input src_addr, input dst_addr,
                    input protocol_number, input src_l4_port, input dst_l4_port,
                    input frame_length, output ready);
endinterface

### rtl/ethernet_ipv4_five_tuple_parser.sv
// Top level: Ethernet IPv4 five-tuple parser with input and result registers.
//
// Usage
//   i_byte   : sink channel of frame bytes, one item per byte, last_byte set on
//              the final byte of the frame. An item moves when valid and ready
//              are both high at a rising edge of i_clk.
//   o_result : source channel, one item per frame, raised for the final byte.
//              It carries the accept flag, addresses, protocol, ports and the
//              frame byte count (saturating at 2^LENGTH_WIDTH - 1).
// Throughput: one byte per cycle unless a final byte waits for the result slot;
//   the parser updates its capture state in a single pass between the input
//   register and the result register. A final byte passes through both.
// Reset (i_rst_n low, synchronous): both registers empty, capture state zero,
//   so the next byte is taken as the first byte of a frame.
// Stall: while a result waits on o_result, ordinary bytes keep flowing into the
//   capture state; only a final byte holds in the input register until the
//   result slot frees, and i_byte.ready drops behind it.
module ethernet_ipv4_five_tuple_parser #(
    parameter int LENGTH_WIDTH = eth5t_pkg::LENGTH_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    eth5t_byte_if.sink       i_byte,
    eth5t_result_if.source   o_result
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result register
    logic               r_out_valid;
    eth5t_pkg::t_result r_out;

    eth5t_pkg::t_result parse_res;
    logic               out_free;
    logic               step;

    // A final byte needs the result slot; other bytes advance at once
    assign out_free = !r_out_valid || o_result.ready;
    assign step     = r_in_valid && (!r_in_last || out_free);

    assign i_byte.ready = !r_in_valid || step;

    eth5t_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (parse_res)
    );

    // Take a new byte whenever the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    // Load the result on the final byte, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= parse_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.accepted        = r_out.accepted;
    assign o_result.src_addr        = r_out.src_addr;
    assign o_result.dst_addr        = r_out.dst_addr;
    assign o_result.protocol_number = r_out.protocol_number;
    assign o_result.src_l4_port     = r_out.src_l4_port;
    assign o_result.dst_l4_port     = r_out.dst_l4_port;
    assign o_result.frame_length    = r_out.frame_length;

    // A held byte must not be lost or overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("held input byte lost or overwritten");

    // A rejected frame carries no addresses, protocol or ports
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.accepted |->
            r_out.src_addr == 32'd0 && r_out.dst_addr == 32'd0 &&
            r_out.protocol_number == 8'd0 && r_out.src_l4_port == 16'd0 &&
            r_out.dst_l4_port == 16'd0)
        else $error("rejected result carries header fields");

    // An accepted frame holds at least Ethernet plus a minimal IPv4 header
    a_accept_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.accepted |->
            r_out.frame_length >= 16'(eth5t_pkg::ETH_HDR_LEN + eth5t_pkg::IPV4_MIN_LEN))
        else $error("accepted result with short frame");

    // Every result counts at least its final byte
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in_last |=> r_out_valid && r_out.frame_length != 16'd0)
        else $error("result with zero frame length");

endmodule

### rtl/eth5t_parser.sv
// Per-frame capture state and result evaluation of the five-tuple parser.
module eth5t_parser #(
    parameter int LENGTH_WIDTH = eth5t_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output eth5t_pkg::t_result  o_result
);

    localparam logic [LENGTH_WIDTH-1:0] COUNT_MAX = {LENGTH_WIDTH{1'b1}};

    logic [LENGTH_WIDTH-1:0] r_count, n_count;
    logic [15:0]             r_ether, n_ether;
    logic [3:0]              r_hw, n_hw;
    logic [12:0]             r_frag, n_frag;
    logic [31:0]             r_src, n_src;
    logic [31:0]             r_dst, n_dst;
    logic [7:0]              r_proto, n_proto;
    logic [15:0]             r_sport, n_sport;
    logic [15:0]             r_dport, n_dport;

    logic [LENGTH_WIDTH-1:0] pos;
    logic [6:0]              toff_cur, toff_new;
    logic [LENGTH_WIDTH-1:0] toff_pos;
    logic [LENGTH_WIDTH-1:0] need_len;
    logic                    ok_base, ok;

    assign pos      = r_count;
    assign toff_cur = 7'(eth5t_pkg::ETH_HDR_LEN) + 7'({r_hw, 2'b00});
    assign toff_pos = LENGTH_WIDTH'(toff_cur);

    // Capture the byte at its position; ports follow the header length
    always_comb begin
        n_count = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        n_ether = r_ether;
        n_hw    = r_hw;
        n_frag  = r_frag;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_sport = r_sport;
        n_dport = r_dport;

        if (pos == LENGTH_WIDTH'(eth5t_pkg::POS_ETYPE_HI) ||
            pos == LENGTH_WIDTH'(eth5t_pkg::POS_ETYPE_LO)) begin
            n_ether = {r_ether[7:0], i_byte};
        end else if (pos == LENGTH_WIDTH'(eth5t_pkg::POS_IHL)) begin
            n_hw = i_byte[3:0];
        end else if (pos == LENGTH_WIDTH'(eth5t_pkg::POS_FRAG_HI) ||
                     pos == LENGTH_WIDTH'(eth5t_pkg::POS_FRAG_LO)) begin
            n_frag = {r_frag[4:0], i_byte};
        end else if (pos == LENGTH_WIDTH'(eth5t_pkg::POS_PROTO)) begin
            n_proto = i_byte;
        end else if (pos inside {[eth5t_pkg::POS_SRC_FIRST:eth5t_pkg::POS_SRC_LAST]}) begin
            n_src = {r_src[23:0], i_byte};
        end else if (pos inside {[eth5t_pkg::POS_DST_FIRST:eth5t_pkg::POS_DST_LAST]}) begin
            n_dst = {r_dst[23:0], i_byte};
        end

        if (pos > LENGTH_WIDTH'(eth5t_pkg::POS_IHL)) begin
            if (pos == toff_pos || pos == toff_pos + 1'b1) begin
                n_sport = {r_sport[7:0], i_byte};
            end else if (pos == toff_pos + 2'd2 || pos == toff_pos + 2'd3) begin
                n_dport = {r_dport[7:0], i_byte};
            end
        end
    end

    // Judge the frame on the state that includes the final byte
    assign toff_new = 7'(eth5t_pkg::ETH_HDR_LEN) + 7'({n_hw, 2'b00});
    assign ok_base  = (n_ether == eth5t_pkg::ETHERTYPE_IPV4) &&
                      (n_count >= LENGTH_WIDTH'(eth5t_pkg::ETH_HDR_LEN +
                                                eth5t_pkg::IPV4_MIN_LEN)) &&
                      (n_hw >= eth5t_pkg::MIN_IHL) && (n_frag == 13'd0);

    always_comb begin
        need_len = LENGTH_WIDTH'(toff_new);
        case (n_proto)
            eth5t_pkg::PROTO_TCP: need_len = LENGTH_WIDTH'(toff_new) +
                                             LENGTH_WIDTH'(eth5t_pkg::TCP_HDR_LEN);
            eth5t_pkg::PROTO_UDP: need_len = LENGTH_WIDTH'(toff_new) +
                                             LENGTH_WIDTH'(eth5t_pkg::UDP_HDR_LEN);
            default:              need_len = '0;
        endcase
    end

    assign ok = ok_base && (n_count >= need_len);

    always_comb begin
        o_result                 = '0;
        o_result.frame_length    = 16'(n_count);
        if (ok) begin
            o_result.accepted        = 1'b1;
            o_result.src_addr        = n_src;
            o_result.dst_addr        = n_dst;
            o_result.protocol_number = n_proto;
            if (n_proto == eth5t_pkg::PROTO_TCP || n_proto == eth5t_pkg::PROTO_UDP) begin
                o_result.src_l4_port = n_sport;
                o_result.dst_l4_port = n_dport;
            end
        end
    end

    // Advance on each parsed byte; clear everything after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count <= '0;
            r_ether <= '0;
            r_hw    <= '0;
            r_frag  <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_proto <= '0;
            r_sport <= '0;
            r_dport <= '0;
        end else if (i_step) begin
            r_count <= n_count;
            r_ether <= n_ether;
            r_hw    <= n_hw;
            r_frag  <= n_frag;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_proto <= n_proto;
            r_sport <= n_sport;
            r_dport <= n_dport;
        end
    end

endmodule

### verif/testbench.sv
// Self-checking testbench of the Ethernet IPv4 five-tuple parser: frame bytes in, one tuple out.
`timescale 1ns / 100ps

module testbench;
    import eth5t_pkg::*;

    localparam int          COUNT_W        = LENGTH_WIDTH_DEF;
    localparam int unsigned COUNT_MAX      = (1 << COUNT_W) - 1;
    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 5;
    // Longest correct quiet spell is a sender gap plus a receiver stall; allow far more.
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int unsigned RANDOM_BYTES   = 150;
    localparam int unsigned RANDOM_FRAMES  = 2;

    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] FLAG_DF        = 16'h4000;
    localparam logic [15:0] FLAG_MF        = 16'h2000;
    localparam logic [15:0] FRAG_OFFSET    = 16'h1FFF;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_RESERVED = 8'd255;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [3:0]  IHL_MAX        = 4'd15;

    typedef logic [7:0] frame_bytes_t[$];

    // Header contents of one stimulus frame, before it is laid out as bytes
    typedef struct {
        logic [15:0] ethertype;
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [15:0] flags_frag;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
        int unsigned length;
    } frame_spec_t;

    // Running capture state of the frame in flight, as the parser should hold it
    typedef struct {
        int unsigned count;
        logic [15:0] ethertype;
        logic [3:0]  ihl;
        logic [12:0] frag;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
    } capture_t;

    logic i_clk;
    logic i_rst_n;

    eth5t_byte_if   byte_ch ();
    eth5t_result_if tuple_ch ();

    ethernet_ipv4_five_tuple_parser #(
        .LENGTH_WIDTH (COUNT_W)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (tuple_ch)
    );

    capture_t    cap = '{default: 0};
    t_result     pending_tuples[$];
    int unsigned mismatches   = 0;
    int unsigned bytes_sent   = 0;
    int unsigned quiet_cycles = 0;

    // Sender burst state; clear gaps_on for back-to-back bytes
    bit          gaps_on    = 1'b1;
    int unsigned burst_left = 0;

    // Receiver stall pattern: rotate a random word, re-roll it now and then
    logic [15:0] stall_bits   = 16'hFFFF;
    int unsigned pattern_left = 0;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Tuple predictor: advance the capture state by one accepted byte and,
    // on the final byte, queue the tuple the parser owes for the frame.
    // ---------------------------------------------------------------------
    function automatic void capture_header_byte(input logic [7:0] b, input logic lst);
        int unsigned pos;
        int unsigned toff;
        int unsigned len;
        logic        ok;
        t_result     tuple;
        pos  = cap.count;
        toff = ETH_HDR_LEN + 4 * cap.ihl;
        if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO)
            cap.ethertype = {cap.ethertype[7:0], b};
        else if (pos == POS_IHL)
            cap.ihl = b[3:0];
        else if (pos == POS_FRAG_HI || pos == POS_FRAG_LO)
            cap.frag = {cap.frag[4:0], b};
        else if (pos == POS_PROTO)
            cap.proto = b;
        else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
            cap.src = {cap.src[23:0], b};
        else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
            cap.dst = {cap.dst[23:0], b};

        // Port bytes sit after the IP header; its length is known from byte 14 on
        if (pos > POS_IHL) begin
            if (pos == toff || pos == toff + 1)
                cap.sport = {cap.sport[7:0], b};
            else if (pos == toff + 2 || pos == toff + 3)
                cap.dport = {cap.dport[7:0], b};
        end

        // Saturate the byte count
        if (cap.count < COUNT_MAX)
            cap.count++;

        if (lst) begin
            len  = cap.count;
            toff = ETH_HDR_LEN + 4 * cap.ihl;
            ok   = (cap.ethertype == ETHERTYPE_IPV4) && (len >= ETH_HDR_LEN + IPV4_MIN_LEN) &&
                   (cap.ihl >= MIN_IHL) && (cap.frag == '0);
            // TCP and UDP also need their whole transport header
            if (ok && cap.proto == PROTO_TCP)
                ok = (len >= toff + TCP_HDR_LEN);
            if (ok && cap.proto == PROTO_UDP)
                ok = (len >= toff + UDP_HDR_LEN);

            // A rejected frame reports its length and nothing else
            tuple              = '0;
            tuple.frame_length = len[15:0];
            if (ok) begin
                tuple.accepted        = 1'b1;
                tuple.src_addr        = cap.src;
                tuple.dst_addr        = cap.dst;
                tuple.protocol_number = cap.proto;
                if (cap.proto == PROTO_TCP || cap.proto == PROTO_UDP) begin
                    tuple.src_l4_port = cap.sport;
                    tuple.dst_l4_port = cap.dport;
                end
            end
            pending_tuples.push_back(tuple);
            cap = '{default: 0};
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Track accepted bytes and check each accepted tuple against the oldest
    // one owed. Both channels are sampled at the edge, before any update.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : track_and_check
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready)
                capture_header_byte(byte_ch.data_byte, byte_ch.last_byte);
            if (tuple_ch.valid && tuple_ch.ready) begin
                seen.accepted        = tuple_ch.accepted;
                seen.src_addr        = tuple_ch.src_addr;
                seen.dst_addr        = tuple_ch.dst_addr;
                seen.protocol_number = tuple_ch.protocol_number;
                seen.src_l4_port     = tuple_ch.src_l4_port;
                seen.dst_l4_port     = tuple_ch.dst_l4_port;
                seen.frame_length    = tuple_ch.frame_length;
                if (pending_tuples.size() == 0) begin
                    mismatches++;
                    $display("%0t: tuple with none owed, expected nothing, actual %h",
                             $time, seen);
                end else begin
                    want = pending_tuples.pop_front();
                    check_field("accepted", want.accepted, seen.accepted);
                    check_field("src_addr", want.src_addr, seen.src_addr);
                    check_field("dst_addr", want.dst_addr, seen.dst_addr);
                    check_field("protocol_number", want.protocol_number,
                                seen.protocol_number);
                    check_field("src_l4_port", want.src_l4_port, seen.src_l4_port);
                    check_field("dst_l4_port", want.dst_l4_port, seen.dst_l4_port);
                    check_field("frame_length", want.frame_length, seen.frame_length);
                end
            end
        end
    end

    // Receiver: stall on a rotating pattern, with spells of no stalling at all
    always @(posedge i_clk) begin
        if (pattern_left == 0) begin
            pattern_left <= $urandom_range(64, 512);
            stall_bits   <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h0001);
        end else begin
            pattern_left <= pattern_left - 1;
            stall_bits   <= {stall_bits[0], stall_bits[15:1]};
        end
        tuple_ch.ready <= stall_bits[0];
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (tuple_ch.valid && tuple_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("ethernet_ipv4_five_tuple_parser test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sender. Called at a rising edge; returns at the edge that takes the
    // item. Gaps open between bursts of random length while gaps_on is set.
    // ---------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic lst);
        int unsigned gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 8);
            if (gap != 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left != 0)
            burst_left--;
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= lst;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    // Hold the sender until every owed tuple has come back
    task automatic wait_for_tuples();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_tuples.size() != 0)
            @(posedge i_clk);
    endtask

    // Shortest frame that carries the whole IP and transport headers
    function automatic int unsigned min_length(input frame_spec_t s);
        int unsigned l4;
        int unsigned need;
        l4   = (s.proto == PROTO_TCP) ? TCP_HDR_LEN :
               (s.proto == PROTO_UDP) ? UDP_HDR_LEN : 0;
        need = ETH_HDR_LEN + 4 * s.ihl + l4;
        return (need > ETH_HDR_LEN + IPV4_MIN_LEN) ? need : ETH_HDR_LEN + IPV4_MIN_LEN;
    endfunction

    // Well-formed, unfragmented IPv4 frame with random addresses and ports
    function automatic frame_spec_t spec_for(input logic [7:0] proto, input logic [3:0] ihl,
                                            input int unsigned extra);
        frame_spec_t s;
        s.ethertype   = ETHERTYPE_IPV4;
        s.version     = IP_VERSION_4;
        s.ihl         = ihl;
        // Any flags, offset zero
        s.flags_frag  = {3'($urandom), 13'h0};
        s.proto       = proto;
        s.src_addr    = $urandom;
        s.dst_addr    = $urandom;
        s.src_l4_port = 16'($urandom);
        s.dst_l4_port = 16'($urandom);
        s.length      = min_length(s) + extra;
        return s;
    endfunction

    // Lay the headers out on random filler, then cut the frame to length
    function automatic frame_bytes_t build_frame(input frame_spec_t s);
        frame_bytes_t f;
        int unsigned  toff;
        int unsigned  span;
        toff = ETH_HDR_LEN + 4 * s.ihl;
        span = s.length;
        if (span < toff + 4)
            span = toff + 4;
        if (span < POS_DST_LAST + 1)
            span = POS_DST_LAST + 1;
        repeat (span) f.push_back(8'($urandom));
        // Ports first: with a short header length the IP fields overwrite them
        f[toff]     = s.src_l4_port[15:8];
        f[toff + 1] = s.src_l4_port[7:0];
        f[toff + 2] = s.dst_l4_port[15:8];
        f[toff + 3] = s.dst_l4_port[7:0];
        f[POS_ETYPE_HI] = s.ethertype[15:8];
        f[POS_ETYPE_LO] = s.ethertype[7:0];
        f[POS_IHL]      = {s.version, s.ihl};
        f[POS_FRAG_HI]  = s.flags_frag[15:8];
        f[POS_FRAG_LO]  = s.flags_frag[7:0];
        f[POS_PROTO]    = s.proto;
        for (int i = 0; i < 4; i++) begin
            f[POS_SRC_FIRST + i] = s.src_addr[31 - 8 * i -: 8];
            f[POS_DST_FIRST + i] = s.dst_addr[31 - 8 * i -: 8];
        end
        while (f.size() > s.length)
            void'(f.pop_back());
        return f;
    endfunction

    task automatic send_frame(input frame_spec_t s);
        frame_bytes_t f;
        f = build_frame(s);
        foreach (f[i])
            push_byte(f[i], i == f.size() - 1);
        bytes_sent += f.size();
    endtask

    // ---------------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------------

    // Length boundaries: whole transport header just there, and one byte short
    task automatic test_minimum_lengths();
        frame_spec_t s;
        send_frame(spec_for(PROTO_UDP, MIN_IHL, 0));
        s = spec_for(PROTO_UDP, MIN_IHL, 0);
        s.length--;
        send_frame(s);
        send_frame(spec_for(PROTO_TCP, MIN_IHL, 0));
        s = spec_for(PROTO_TCP, MIN_IHL, 0);
        s.length--;
        send_frame(s);
        // Other protocols need only the bare IP header
        send_frame(spec_for(PROTO_ICMP, MIN_IHL, 0));
        s = spec_for(PROTO_ICMP, MIN_IHL, 0);
        s.length--;
        send_frame(s);
        // Single-byte frame
        s.length = 1;
        send_frame(s);
    endtask

    // EtherType, fragment and header length checks
    task automatic test_header_checks();
        frame_spec_t s;
        s = spec_for(PROTO_TCP, MIN_IHL, 4);
        s.ethertype = ETHERTYPE_IPV6;
        send_frame(s);
        s.ethertype = ETHERTYPE_ARP;
        send_frame(s);
        s.ethertype = '0;
        send_frame(s);
        s.ethertype = '1;
        send_frame(s);
        // Non-zero offset rejects; flags alone do not
        s = spec_for(PROTO_UDP, MIN_IHL, 2);
        s.flags_frag = 16'h0001;
        send_frame(s);
        s.flags_frag = FRAG_OFFSET;
        send_frame(s);
        s.flags_frag = FLAG_MF;
        send_frame(s);
        s.flags_frag = FLAG_DF | FLAG_MF;
        send_frame(s);
        // Short header length rejects
        s = spec_for(PROTO_UDP, MIN_IHL, 8);
        s.ihl = MIN_IHL - 1;
        send_frame(s);
        s.ihl = '0;
        send_frame(s);
        // Longest header: ports land after forty bytes of options
        send_frame(spec_for(PROTO_TCP, IHL_MAX, 0));
        s = spec_for(PROTO_UDP, IHL_MAX, 0);
        s.length--;
        send_frame(s);
    endtask

    // Extremes of addresses, ports, protocol and version
    task automatic test_field_extremes();
        frame_spec_t s;
        s = spec_for(PROTO_TCP, MIN_IHL, 3);
        s.src_addr    = '1;
        s.dst_addr    = '1;
        s.src_l4_port = '1;
        s.dst_l4_port = '1;
        s.version     = '1;
        send_frame(s);
        s = spec_for(PROTO_UDP, MIN_IHL, 0);
        s.src_addr    = '0;
        s.dst_addr    = '0;
        s.src_l4_port = '0;
        s.dst_l4_port = '0;
        s.version     = '0;
        send_frame(s);
        // Other protocols report zero ports even when the bytes are there
        s = spec_for(PROTO_RESERVED, MIN_IHL, 12);
        s.src_addr = '1;
        s.dst_addr = '1;
        send_frame(s);
        s.proto = '0;
        send_frame(s);
    endtask

    // Mostly well-formed frames, some broken ones, some noise
    task automatic test_random_traffic();
        frame_spec_t s;
        int unsigned frames;
        int unsigned kind;
        int unsigned extra;
        int unsigned start;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        bit          paused;
        frames = 0;
        paused = 1'b0;
        start  = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
            // Spells with no sender gaps at all
            gaps_on = ($urandom_range(0, 4) != 0);
            // Drain everything once, mid-run
            if (!paused && frames == RANDOM_FRAMES / 2) begin
                wait_for_tuples();
                paused = 1'b1;
            end
            case ($urandom_range(0, 3))
                0, 1:    proto = PROTO_TCP;
                2:       proto = PROTO_UDP;
                default: proto = 8'($urandom);
            endcase
            ihl   = ($urandom_range(0, 1) != 0) ? MIN_IHL : 4'($urandom_range(6, 15));
            extra = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            s     = spec_for(proto, ihl, extra);
            if ($urandom_range(0, 7) == 0)
                s.version = 4'($urandom);
            kind = $urandom_range(0, 99);
            if (kind >= 90) begin
                // Noise: any header contents, any length
                s.ethertype  = ($urandom_range(0, 1) != 0) ? ETHERTYPE_IPV4 : 16'($urandom);
                s.ihl        = 4'($urandom);
                s.flags_frag = 16'($urandom);
                s.proto      = 8'($urandom);
                s.length     = $urandom_range(1, 80);
            end else if (kind >= 70) begin
                // Broken: one fault in an otherwise good frame
                case ($urandom_range(0, 3))
                    0:       s.length = $urandom_range(1, s.length - 1);
                    1:       s.ethertype = 16'($urandom);
                    2:       s.flags_frag[12:0] = 13'($urandom_range(1, FRAG_OFFSET));
                    default: s.ihl = 4'($urandom_range(0, MIN_IHL - 1));
                endcase
            end
            send_frame(s);
            frames++;
        end
        gaps_on = 1'b1;
    endtask

    // ---------------------------------------------------------------------
    // Sequence: reset once, run each test in turn, drain, then report.
    // ---------------------------------------------------------------------
    initial begin
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        tuple_ch.ready    = 1'b0;
        i_rst_n           = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_minimum_lengths();
        test_header_checks();
        test_field_extremes();
        test_random_traffic();

        // Let the last tuples out, then watch for stray ones
        wait_for_tuples();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_tuples.size() == 0)
            $display("ethernet_ipv4_five_tuple_parser test passed");
        else
            $display("ethernet_ipv4_five_tuple_parser test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/eth5t_pkg.sv
rtl/eth5t_if.sv
rtl/eth5t_parser.sv
rtl/ethernet_ipv4_five_tuple_parser.sv
verif/testbench.sv
